### hdl/button_switch_debounce_long_press_defines.svh
// Assertion macros for the button/switch debouncer.
// Used by button_switch_debounce_long_press; expects clk and rst in scope.
`ifndef BUTTON_SWITCH_DEBOUNCE_LONG_PRESS_DEFINES_SVH
`define BUTTON_SWITCH_DEBOUNCE_LONG_PRESS_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BSDLP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BSDLP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/bsdlp_pkg.sv
// Types and constants for the button/switch debouncer.
// No dependencies; imported by button_switch_debounce_long_press.
`timescale 1ns / 1ps

package bsdlp_pkg;

  localparam int CFG_WIDTH = 16;

  typedef logic [CFG_WIDTH-1:0] cfg_word_t;
  typedef logic [1:0]           cfg_index_t;
  typedef logic [1:0]           event_code_t;

  // Register indexes
  localparam cfg_index_t CFG_BUTTON_DEBOUNCE = 2'd0;
  localparam cfg_index_t CFG_SWITCH_DEBOUNCE = 2'd1;
  localparam cfg_index_t CFG_LONG_PRESS      = 2'd2;

  // Register reset values
  localparam cfg_word_t BUTTON_DEBOUNCE_RESET = 16'd50;
  localparam cfg_word_t SWITCH_DEBOUNCE_RESET = 16'd50;
  localparam cfg_word_t LONG_PRESS_RESET      = 16'd1000;

  // Button event codes
  localparam event_code_t BTN_EV_NONE          = 2'd0;
  localparam event_code_t BTN_EV_PRESSED       = 2'd1;
  localparam event_code_t BTN_EV_SHORT_RELEASE = 2'd2;
  localparam event_code_t BTN_EV_LONG_RELEASE  = 2'd3;

  // Switch event codes
  localparam event_code_t SW_EV_NONE = 2'd0;
  localparam event_code_t SW_EV_ON   = 2'd1;
  localparam event_code_t SW_EV_OFF  = 2'd2;

  // Pins are active low
  localparam logic PIN_ACTIVE = 1'b0;
  localparam logic PIN_IDLE   = 1'b1;

endpackage

### hdl/button_switch_debounce_long_press.sv
// Button and mode-switch debouncer with long-press classification.
// Depends on bsdlp_pkg and button_switch_debounce_long_press_defines.svh.
//
//  channel | handshake              | payload
//  --------+------------------------+------------------------------------------
//  in      | in_valid / in_ready    | button_level, switch_level
//  out     | out_valid / out_ready  | button_event, switch_event, button_held,
//          |                        | switch_on
//  cfg     | cfg_we                 | cfg_index, cfg_data
//
// One transaction per cycle unless a result waits on out_ready: a sample's
// result appears in the cycle after it is taken, computed by one pass from the
// pin state registers into the output register. in_ready is low only while the
// output register holds a result that out_ready has not taken. Synchronous
// reset clears state and restores register defaults; no other start-up time.
`timescale 1ns / 1ps
`include "button_switch_debounce_long_press_defines.svh"

module button_switch_debounce_long_press
  import bsdlp_pkg::*;
#(
  parameter int AGE_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        button_level,
  input  logic        switch_level,
  output logic        out_valid,
  input  logic        out_ready,
  output event_code_t button_event,
  output event_code_t switch_event,
  output logic        button_held,
  output logic        switch_on,
  input  logic        cfg_we,
  input  cfg_index_t  cfg_index,
  input  cfg_word_t   cfg_data
);

  localparam int CMP_WIDTH = (AGE_WIDTH > CFG_WIDTH) ? AGE_WIDTH : CFG_WIDTH;
  localparam logic [AGE_WIDTH-1:0] AGE_MAX = {AGE_WIDTH{1'b1}};

  typedef logic [AGE_WIDTH-1:0] age_t;
  typedef logic [CMP_WIDTH-1:0] cmp_t;

  cfg_word_t button_debounce_ticks;
  cfg_word_t switch_debounce_ticks;
  cfg_word_t long_press_ticks;

  logic button_last_raw, button_last_raw_next;
  logic button_stable, button_stable_next;
  age_t button_age, button_age_next;
  logic switch_last_raw, switch_last_raw_next;
  logic switch_stable, switch_stable_next;
  age_t switch_age, switch_age_next;
  age_t press_age, press_age_next;

  logic        accept;
  logic        button_change;
  logic        switch_change;
  age_t        press_age_inc;
  event_code_t button_event_next;
  event_code_t switch_event_next;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      button_debounce_ticks <= BUTTON_DEBOUNCE_RESET;
      switch_debounce_ticks <= SWITCH_DEBOUNCE_RESET;
      long_press_ticks      <= LONG_PRESS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BUTTON_DEBOUNCE: button_debounce_ticks <= cfg_data;
        CFG_SWITCH_DEBOUNCE: switch_debounce_ticks <= cfg_data;
        CFG_LONG_PRESS:      long_press_ticks      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    // Switch pin
    switch_last_raw_next = switch_level;
    if (switch_level != switch_last_raw) begin
      switch_age_next = '0;
    end else begin
      switch_age_next = (switch_age == AGE_MAX) ? switch_age : switch_age + 1'b1;
    end
    switch_change = (cmp_t'(switch_age_next) >= cmp_t'(switch_debounce_ticks))
                    && (switch_stable != switch_level);
    switch_stable_next = switch_change ? switch_level : switch_stable;
    switch_event_next  = SW_EV_NONE;
    if (switch_change) begin
      switch_event_next = (switch_level == PIN_ACTIVE) ? SW_EV_ON : SW_EV_OFF;
    end

    // Button pin
    button_last_raw_next = button_level;
    if (button_level != button_last_raw) begin
      button_age_next = '0;
    end else begin
      button_age_next = (button_age == AGE_MAX) ? button_age : button_age + 1'b1;
    end
    button_change = (cmp_t'(button_age_next) >= cmp_t'(button_debounce_ticks))
                    && (button_stable != button_level);
    button_stable_next = button_change ? button_level : button_stable;

    // Hold timer restarts on an accepted press
    press_age_inc     = (press_age == AGE_MAX) ? press_age : press_age + 1'b1;
    press_age_next    = press_age_inc;
    button_event_next = BTN_EV_NONE;
    if (button_change) begin
      if (button_level == PIN_ACTIVE) begin
        press_age_next    = '0;
        button_event_next = BTN_EV_PRESSED;
      end else if (cmp_t'(press_age_inc) >= cmp_t'(long_press_ticks)) begin
        button_event_next = BTN_EV_LONG_RELEASE;
      end else begin
        button_event_next = BTN_EV_SHORT_RELEASE;
      end
    end
  end

  // Pin state
  always_ff @(posedge clk) begin
    if (rst) begin
      button_last_raw <= PIN_IDLE;
      button_stable   <= PIN_IDLE;
      button_age      <= '0;
      switch_last_raw <= PIN_IDLE;
      switch_stable   <= PIN_IDLE;
      switch_age      <= '0;
      press_age       <= '0;
    end else if (accept) begin
      button_last_raw <= button_last_raw_next;
      button_stable   <= button_stable_next;
      button_age      <= button_age_next;
      switch_last_raw <= switch_last_raw_next;
      switch_stable   <= switch_stable_next;
      switch_age      <= switch_age_next;
      press_age       <= press_age_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      button_event <= button_event_next;
      switch_event <= switch_event_next;
      button_held  <= (button_stable_next == PIN_ACTIVE);
      switch_on    <= (switch_stable_next == PIN_ACTIVE);
    end
  end

  `BSDLP_ASSERT_NEXT(a_accept_gives_result, accept, out_valid, "accepted sample produced no result")
  `BSDLP_ASSERT_NOW(a_press_held, out_valid && (button_event == BTN_EV_PRESSED), button_held, "press event without held button")
  `BSDLP_ASSERT_NOW(a_release_not_held, out_valid && ((button_event == BTN_EV_SHORT_RELEASE) || (button_event == BTN_EV_LONG_RELEASE)), !button_held, "release event while button held")
  `BSDLP_ASSERT_NOW(a_switch_event_level, out_valid && (switch_event != SW_EV_NONE), switch_on == (switch_event == SW_EV_ON), "switch event disagrees with switch level")

endmodule
